// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the grid neighbor expander modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GNE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define GNE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/gne_pkg.sv -----
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types, op codes and neighbor step tables for the grid neighbor
// expander.
// ----------------------------------------------------------------------------
package gne_pkg;

    localparam int MAP_COLS_DEF = 256;
    localparam int MAP_ROWS_DEF = 256;

    // bitmap word geometry
    localparam int WORD_W     = 32;
    localparam int WORD_BIT_W = 5;

    localparam logic [2:0] OP_FREE_NBRS = 3'd0;
    localparam logic [2:0] OP_ALL_NBRS  = 3'd1;
    localparam logic [2:0] OP_BLOCK     = 3'd2;
    localparam logic [2:0] OP_UNBLOCK   = 3'd3;
    localparam logic [2:0] OP_QUERY     = 3'd4;
    localparam logic [2:0] OP_CLEAR     = 3'd5;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_NBR_MODE    = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] nbr_x;
        logic signed [15:0] nbr_y;
        logic               has_coord;
        logic               flag;
        logic               last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       accept;     // input transfer this cycle
        logic       center;     // address the item's own cell, not a neighbor
        logic       rd_en;      // bitmap word read
        logic       scan;       // read belongs to a neighbor scan
        logic       rmw_eval;   // evaluate block/unblock/query on read word
        logic       emit_nbr;   // load next neighbor result into output reg
        logic       emit_resp;  // load single response into output reg
        logic       clr_we;     // clearing sweep write
        logic [2:0] k;          // neighbor table index
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic nbr_last;   // next neighbor result is the final one
    } t_status;

    function automatic logic signed [1:0] step_dx(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0:    d = 2'b00;
            3'd1:    d = 2'b11;
            3'd2:    d = 2'b01;
            3'd3:    d = 2'b00;
            3'd4:    d = 2'b11;
            3'd5:    d = 2'b11;
            3'd6:    d = 2'b01;
            default: d = 2'b01;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0:    d = 2'b11;
            3'd1:    d = 2'b00;
            3'd2:    d = 2'b00;
            3'd3:    d = 2'b01;
            3'd4:    d = 2'b11;
            3'd5:    d = 2'b01;
            3'd6:    d = 2'b11;
            default: d = 2'b01;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/gne_ctrl.sv -----
// ----------------------------------------------------------------------------
// gne_ctrl
// Sequencer for the grid neighbor expander: clearing sweep, neighbor scan
// and emission, read-modify-write of single cells, single responses.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gne_ctrl #(
    parameter int MAP_COLS = gne_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = gne_pkg::MAP_ROWS_DEF,
    localparam int WORDS   = (MAP_COLS * MAP_ROWS + gne_pkg::WORD_W - 1) / gne_pkg::WORD_W,
    localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_op,
    input  logic              i_mode,
    input  gne_pkg::t_status  i_status,
    output gne_pkg::t_cmd     o_cmd,
    output logic [AW-1:0]     o_clr_addr
);
    import gne_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_k, n_k;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_clr_resp, n_clr_resp;
    logic [2:0]    last_k;

    assign last_k     = i_mode ? 3'd7 : 3'd3;
    assign o_clr_addr = r_cnt;

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_clr_resp = r_clr_resp;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.k    = r_k;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (r_cnt == LAST_WORD) begin
                    n_cnt   = '0;
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    unique case (i_op) inside
                        OP_FREE_NBRS, OP_ALL_NBRS: begin
                            n_k     = 3'd0;
                            n_state = S_SCAN;
                        end
                        OP_BLOCK, OP_UNBLOCK, OP_QUERY: n_state = S_RD;
                        OP_CLEAR: begin
                            n_clr_resp = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.scan  = 1'b1;
                if (r_k == last_k) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_nbr = 1'b1;
                    if (i_status.nbr_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.center = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                o_cmd.rmw_eval = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.emit_resp = 1'b1;
                    n_clr_resp      = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_k        <= '0;
            r_cnt      <= '0;
            r_clr_resp <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_cnt      <= n_cnt;
            r_clr_resp <= n_clr_resp;
        end
    end

    `GNE_ASSERT_IMP(a_emit_needs_slot, i_clk, i_rst_n,
        o_cmd.emit_nbr || o_cmd.emit_resp, i_status.out_free)
    `GNE_ASSERT_NXT(a_sweep_end_idle, i_clk, i_rst_n,
        r_state == S_CLEAR && r_cnt == LAST_WORD && !r_clr_resp, o_in_ready)

endmodule

// ----- hdl/gne_datapath.sv -----
// ----------------------------------------------------------------------------
// gne_datapath
// Blocked-cell bitmap memory, neighbor bounds and address logic, candidate
// mask and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gne_datapath #(
    parameter int MAP_COLS = gne_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = gne_pkg::MAP_ROWS_DEF,
    localparam int WORDS   = (MAP_COLS * MAP_ROWS + gne_pkg::WORD_W - 1) / gne_pkg::WORD_W,
    localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gne_pkg::t_in_item  i_in_data,
    input  gne_pkg::t_cmd      i_cmd,
    input  logic [AW-1:0]      i_clr_addr,
    input  logic [14:0]        i_grid_width,
    input  logic [14:0]        i_grid_height,
    output gne_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gne_pkg::t_out_item o_out_data
);
    import gne_pkg::*;

    localparam int IW = AW + WORD_BIT_W;
    localparam logic [IW-1:0] COLS_IW = IW'(MAP_COLS);
    localparam logic [16:0]   COLS17  = 17'(MAP_COLS);
    localparam logic [16:0]   ROWS17  = 17'(MAP_ROWS);

    logic [WORD_W-1:0] mem [0:WORDS-1];

    // held item
    logic [2:0]        r_op;
    logic [15:0]       r_x, r_y;
    logic [IW-1:0]     r_base;
    logic [IW+15:0]    y_ext;

    // read stage
    logic [WORD_W-1:0]     r_rd_word;
    logic [AW-1:0]         r_ev_addr;
    logic [WORD_BIT_W-1:0] r_ev_bit;
    logic [2:0]            r_ev_k;
    logic                  r_ev_ok, r_ev_inmap, r_ev_scan;

    logic [7:0]        r_mask;
    logic              r_flag;
    logic              r_out_vld;
    t_out_item         r_out;

    // candidate address path
    logic signed [1:0] dx, dy;
    logic [16:0]       nx, ny;
    logic              x_ok, y_ok, x_inmap, y_inmap;
    logic [IW-1:0]     row_base, idx;

    // evaluation
    logic              bit_set, blocked, mem_we;
    logic [WORD_W-1:0] wr_word;

    // emission
    logic [2:0]        k_e;
    logic signed [1:0] ex, ey;
    t_out_item         nbr_item;
    t_out_item         resp_item;

    assign y_ext = {{IW{i_in_data.cell_y[15]}}, i_in_data.cell_y};

    always_comb begin
        dx = i_cmd.center ? 2'b00 : step_dx(i_cmd.k);
        dy = i_cmd.center ? 2'b00 : step_dy(i_cmd.k);
        nx = {r_x[15], r_x} + {{15{dx[1]}}, dx};
        ny = {r_y[15], r_y} + {{15{dy[1]}}, dy};
        // axis in 16-bit range and within the grid size (zero: unbounded)
        x_ok = (nx[16] == nx[15])
               && (i_grid_width == 15'd0 || (!nx[16] && nx[15:0] < {1'b0, i_grid_width}));
        y_ok = (ny[16] == ny[15])
               && (i_grid_height == 15'd0 || (!ny[16] && ny[15:0] < {1'b0, i_grid_height}));
        x_inmap = !nx[16] && (nx < COLS17);
        y_inmap = !ny[16] && (ny < ROWS17);
        case (dy)
            2'b11:   row_base = r_base - COLS_IW;
            2'b01:   row_base = r_base + COLS_IW;
            default: row_base = r_base;
        endcase
        idx = row_base + IW'(nx);
    end

    assign bit_set = r_rd_word[r_ev_bit];
    assign blocked = r_ev_inmap && bit_set;
    assign mem_we  = i_cmd.rmw_eval && r_ev_inmap && (r_op == OP_BLOCK || r_op == OP_UNBLOCK);

    always_comb begin
        wr_word           = r_rd_word;
        wr_word[r_ev_bit] = (r_op == OP_BLOCK);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            mem[i_clr_addr] <= '0;
        end else if (mem_we) begin
            mem[r_ev_addr] <= wr_word;
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= mem[idx[IW-1:WORD_BIT_W]];
        end
    end

    assign resp_item = '{16'sd0, 16'sd0, 1'b0, r_flag, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_in_data.op;
            r_x    <= i_in_data.cell_x;
            r_y    <= i_in_data.cell_y;
            r_base <= y_ext[IW-1:0] * COLS_IW;
        end
        if (i_cmd.rd_en) begin
            r_ev_addr  <= idx[IW-1:WORD_BIT_W];
            r_ev_bit   <= idx[WORD_BIT_W-1:0];
            r_ev_k     <= i_cmd.k;
            r_ev_ok    <= x_ok && y_ok;
            r_ev_inmap <= x_inmap && y_inmap;
        end
        if (i_cmd.emit_nbr || i_cmd.emit_resp) begin
            r_out <= i_cmd.emit_nbr ? nbr_item : resp_item;
        end
    end

    // lowest pending candidate goes out first
    always_comb begin
        k_e = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (r_mask[i]) begin
                k_e = 3'(i);
            end
        end
        ex = step_dx(k_e);
        ey = step_dy(k_e);
        if (r_mask == 8'd0) begin
            nbr_item = '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1};
        end else begin
            nbr_item.nbr_x     = r_x + {{14{ex[1]}}, ex};
            nbr_item.nbr_y     = r_y + {{14{ey[1]}}, ey};
            nbr_item.has_coord = 1'b1;
            nbr_item.flag      = 1'b0;
            nbr_item.last      = o_status.nbr_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_ev_scan <= 1'b0;
            r_flag    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ev_scan <= i_cmd.rd_en && i_cmd.scan;
            if (i_cmd.accept) begin
                r_mask <= '0;
                r_flag <= 1'b0;
            end else if (r_ev_scan) begin
                if (r_ev_ok && (r_op == OP_ALL_NBRS || !blocked)) begin
                    r_mask[r_ev_k] <= 1'b1;
                end
            end else if (i_cmd.emit_nbr) begin
                r_mask[k_e] <= 1'b0;
            end
            if (i_cmd.rmw_eval) begin
                r_flag <= (r_op == OP_BLOCK) ? (r_ev_inmap && !bit_set) : blocked;
            end
            if (i_cmd.emit_nbr || i_cmd.emit_resp) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_vld || i_out_ready;
    assign o_status.nbr_last = (r_mask & (r_mask - 8'd1)) == 8'd0;
    assign o_out_valid       = r_out_vld;
    assign o_out_data        = r_out;

    `GNE_ASSERT_NXT(a_emit_loads_out, i_clk, i_rst_n,
        i_cmd.emit_nbr || i_cmd.emit_resp, o_out_valid)
    `GNE_ASSERT_NXT(a_empty_list_marked, i_clk, i_rst_n,
        i_cmd.emit_nbr && r_mask == 8'd0, !o_out_data.has_coord && o_out_data.last)

endmodule

// ----- hdl/grid_neighbor_expander.sv -----
// Neighbor ops accept the item, make N = 4 or 8 candidate reads of the single
// bitmap read port, one per cycle, then emit E results (at least one) through
// the output register. Block, unblock and query: accept, read, modify-write,
// respond. Clear and reset sweep ceil(MAP_COLS*MAP_ROWS/32) bitmap words
// (2048 at 256x256), one 32-bit word per cycle; no items are taken meanwhile.
// Reset is synchronous, active low; grid registers reset to zero.
// ----------------------------------------------------------------------------
// grid_neighbor_expander
// Blocked-cell bitmap with 4/8-connected neighbor listing, APB configuration.
// ----------------------------------------------------------------------------
module grid_neighbor_expander #(
    parameter int MAP_COLS = gne_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = gne_pkg::MAP_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gne_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gne_pkg::t_out_item o_out_data
);
    import gne_pkg::*;

    localparam int WORDS = (MAP_COLS * MAP_ROWS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [14:0]   r_grid_width, r_grid_height;
    logic          r_neighbor_mode;
    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] clr_addr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width    <= '0;
            r_grid_height   <= '0;
            r_neighbor_mode <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_GRID_WIDTH:  r_grid_width    <= pwdata[14:0];
                REG_GRID_HEIGHT: r_grid_height   <= pwdata[14:0];
                REG_NBR_MODE:    r_neighbor_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GRID_WIDTH:  prdata = {17'd0, r_grid_width};
            REG_GRID_HEIGHT: prdata = {17'd0, r_grid_height};
            REG_NBR_MODE:    prdata = {31'd0, r_neighbor_mode};
            default:         prdata = '0;
        endcase
    end

    gne_ctrl #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_in_data.op),
        .i_mode     (r_neighbor_mode),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_clr_addr (clr_addr)
    );

    gne_datapath #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .i_clr_addr    (clr_addr),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

// ----- tb/grid_neighbor_expander_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_neighbor_expander_tb
// Self-checking bench for the grid neighbor expander. A directed table and
// then randomized phases drive cells through the item channel. Grid settings
// are changed over APB between phases. Every result is compared against an
// in-bench bitmap and neighbor predictor, or against the table's expected flag.
// ----------------------------------------------------------------------------
module grid_neighbor_expander_tb;
    import gne_pkg::*;

    localparam int MAP_COLS  = MAP_COLS_DEF;
    localparam int MAP_ROWS  = MAP_ROWS_DEF;
    localparam int MAP_CELLS = MAP_COLS * MAP_ROWS;

    // clear sweep length plus margin; used for the idle pause and the drain at the end
    localparam int SETTLE_CYCLES  = (MAP_CELLS + 31) / 32 + 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 6;

    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    localparam logic [3:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
    localparam logic [3:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};
    localparam logic [3:0] ADDR_NBR_MODE    = {REG_NBR_MODE, 2'b00};
    localparam logic [3:0] ADDR_UNMAPPED    = 4'hC;

    localparam int STEP_DX [8] = '{0, -1, 1, 0, -1, -1, 1, 1};
    localparam int STEP_DY [8] = '{-1, 0, 0, 1, -1, 1, -1, 1};

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_in_item    item;
        logic        flag;
        logic [14:0] w;
        logic [14:0] h;
        logic        m;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        o_in_ready;
    t_in_item    in_data;
    logic        o_out_valid;
    logic        out_ready;
    t_out_item   o_out_data;

    // predictor state
    bit          blocked_cells [MAP_CELLS];
    logic [14:0] grid_w;
    logic [14:0] grid_h;
    logic        nbr_mode;

    t_out_item   pending_results [$];
    t_out_item   step_results [$];
    t_stim_row   stim_rows [$];

    int errors;
    int results_seen;
    int stall_cycles;
    bit long_hold_done;

    grid_neighbor_expander dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic bit in_map(int x, int y);
        return x >= 0 && y >= 0 && x < MAP_COLS && y < MAP_ROWS;
    endfunction

    function automatic bit cell_blocked(int x, int y);
        if (!in_map(x, y)) return 1'b0;
        return blocked_cells[y * MAP_COLS + x];
    endfunction

    function automatic bit axis_ok(int v, int limit);
        if (v < -32768 || v > 32767) return 1'b0;
        return limit == 0 || (v >= 0 && v < limit);
    endfunction

    function automatic t_out_item resp_only(logic flag);
        t_out_item r;
        r      = '0;
        r.flag = flag;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void expand_item(t_in_item it);
        t_out_item lst [8];
        int        n;
        int        nx;
        int        ny;
        int        cx;
        int        cy;
        bit        was;
        cx = $signed(it.cell_x);
        cy = $signed(it.cell_y);
        n  = 0;
        step_results.delete();
        case (it.op)
            OP_FREE_NBRS, OP_ALL_NBRS: begin
                for (int k = 0; k < (nbr_mode ? 8 : 4); k++) begin
                    nx = cx + STEP_DX[k];
                    ny = cy + STEP_DY[k];
                    if (axis_ok(nx, int'(grid_w)) && axis_ok(ny, int'(grid_h)) &&
                        !(it.op == OP_FREE_NBRS && cell_blocked(nx, ny))) begin
                        lst[n]           = '0;
                        lst[n].nbr_x     = 16'(nx);
                        lst[n].nbr_y     = 16'(ny);
                        lst[n].has_coord = 1'b1;
                        n++;
                    end
                end
                if (n == 0) begin
                    step_results.push_back(resp_only(1'b0));
                end else begin
                    lst[n-1].last = 1'b1;
                    for (int i = 0; i < n; i++) step_results.push_back(lst[i]);
                end
            end
            OP_BLOCK, OP_UNBLOCK: begin
                if (!in_map(cx, cy)) begin
                    step_results.push_back(resp_only(1'b0));
                end else begin
                    was = blocked_cells[cy * MAP_COLS + cx];
                    blocked_cells[cy * MAP_COLS + cx] = (it.op == OP_BLOCK);
                    step_results.push_back(resp_only(it.op == OP_BLOCK ? !was : was));
                end
            end
            OP_QUERY: step_results.push_back(resp_only(cell_blocked(cx, cy)));
            OP_CLEAR: begin
                foreach (blocked_cells[i]) blocked_cells[i] = 1'b0;
                step_results.push_back(resp_only(1'b0));
            end
            default: step_results.push_back(resp_only(1'b0));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_item(logic [2:0] op, int x, int y);
        t_stim_row r;
        r      = '{kind: ROW_ITEM, item: '0, flag: 1'b0, w: '0, h: '0, m: 1'b0};
        r.item = '{op: op, cell_x: 16'(x), cell_y: 16'(y)};
        stim_rows.push_back(r);
    endfunction

    function automatic void add_typed(logic [2:0] op, int x, int y, logic flag);
        t_stim_row r;
        r      = '{kind: ROW_TYPED, item: '0, flag: flag, w: '0, h: '0, m: 1'b0};
        r.item = '{op: op, cell_x: 16'(x), cell_y: 16'(y)};
        stim_rows.push_back(r);
    endfunction

    function automatic void add_cfg(int w, int h, logic m);
        t_stim_row r;
        r = '{kind: ROW_CFG, item: '0, flag: 1'b0, w: 15'(w), h: 15'(h), m: m};
        stim_rows.push_back(r);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // coordinates cluster near the origin or the far bitmap edge so that
    // blocked cells show up in neighbor lists
    function automatic logic [15:0] pick_coord(int limit);
        int span;
        span = (limit == 0 || limit > 14) ? 14 : limit + 2;
        case ($urandom_range(0, 19))
            0, 1:    return 16'($urandom);
            2:       return 16'(32767 - $urandom_range(0, 2));
            3:       return 16'(-32768 + $urandom_range(0, 2));
            4, 5:    return 16'(250 + $urandom_range(0, 7));
            default: return 16'($urandom_range(0, span) - 1);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 24)      it.op = OP_FREE_NBRS;
        else if (r < 36) it.op = OP_ALL_NBRS;
        else if (r < 60) it.op = OP_BLOCK;
        else if (r < 70) it.op = OP_UNBLOCK;
        else if (r < 88) it.op = OP_QUERY;
        else if (r < 91) it.op = OP_CLEAR;
        else if (r < 95) it.op = ($urandom_range(0, 1) != 0) ? OP_RSVD_A : OP_RSVD_B;
        else             it.op = 3'($urandom);
        it.cell_x = pick_coord(int'(grid_w));
        it.cell_y = pick_coord(int'(grid_h));
        return it;
    endfunction

    // valid stays up across back-to-back items; it only drops for a gap or a drain
    task automatic send_item(t_in_item item, int gap, bit typed, logic flag);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        do @(posedge i_clk); while (!o_in_ready);
        expand_item(item);
        if (typed) begin
            pending_results.push_back(resp_only(flag));
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(bit wr, logic [3:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // upper pwdata bits are junk; the block keeps only the register width
    task automatic program_grid(logic [14:0] w, logic [14:0] h, logic m);
        logic [31:0] rd;
        logic [31:0] want [3];
        logic [3:0]  addr [3];
        apb_xfer(1'b1, ADDR_GRID_WIDTH, {17'($urandom), w}, rd);
        apb_xfer(1'b1, ADDR_GRID_HEIGHT, {17'($urandom), h}, rd);
        apb_xfer(1'b1, ADDR_NBR_MODE, {31'($urandom), m}, rd);
        apb_xfer(1'b1, ADDR_UNMAPPED, $urandom, rd);
        grid_w   = w;
        grid_h   = h;
        nbr_mode = m;
        addr = '{ADDR_GRID_WIDTH, ADDR_GRID_HEIGHT, ADDR_NBR_MODE};
        want = '{{17'd0, w}, {17'd0, h}, {31'd0, m}};
        for (int i = 0; i < 3; i++) begin
            apb_xfer(1'b0, addr[i], 32'd0, rd);
            if (rd !== want[i]) begin
                errors++;
                $display("%0t: register readback at 0x%0h: expected %h, got %h",
                         $time, addr[i], want[i], rd);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin
        int run;
        int gap;
        out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!long_hold_done && results_seen >= 150 && in_valid) begin
                // long back-pressure while the sender keeps offering items
                long_hold_done = 1'b1;
                @(negedge i_clk);
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
            @(negedge i_clk);
            out_ready = 1'b1;
            repeat (run - 1) @(negedge i_clk);
            gap = rand_gap();
            if (gap > 0) begin
                @(negedge i_clk);
                out_ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n && o_out_valid && out_ready) begin
            got = o_out_data;
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: x=%0d y=%0d has=%0b flag=%0b last=%0b",
                         $time, $signed(got.nbr_x), $signed(got.nbr_y),
                         got.has_coord, got.flag, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.nbr_x !== want.nbr_x || got.nbr_y !== want.nbr_y ||
                    got.has_coord !== want.has_coord || got.flag !== want.flag ||
                    got.last !== want.last) begin
                    errors++;
                    $display("%0t: result mismatch: expected x=%0d y=%0d has=%0b flag=%0b last=%0b",
                             $time, $signed(want.nbr_x), $signed(want.nbr_y),
                             want.has_coord, want.flag, want.last);
                    $display("%0t:                  actual x=%0d y=%0d has=%0b flag=%0b last=%0b",
                             $time, $signed(got.nbr_x), $signed(got.nbr_y),
                             got.has_coord, got.flag, got.last);
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_in_item it;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_data  = '0;
        errors   = 0;
        results_seen   = 0;
        long_hold_done = 1'b0;
        grid_w   = '0;
        grid_h   = '0;
        nbr_mode = 1'b0;
        foreach (blocked_cells[i]) blocked_cells[i] = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: both axes unbounded, four-connected
        add_typed(OP_QUERY, 0, 0, 1'b0);
        add_typed(OP_BLOCK, 0, 0, 1'b1);
        add_typed(OP_BLOCK, 0, 0, 1'b0);
        add_typed(OP_QUERY, 0, 0, 1'b1);
        add_item(OP_FREE_NBRS, 1, 0);
        add_item(OP_ALL_NBRS, 1, 0);
        add_typed(OP_UNBLOCK, 0, 0, 1'b1);
        add_typed(OP_UNBLOCK, 0, 0, 1'b0);
        add_typed(OP_BLOCK, -1, 5, 1'b0);
        add_typed(OP_BLOCK, MAP_COLS, 0, 1'b0);
        add_typed(OP_BLOCK, MAP_COLS - 1, MAP_ROWS - 1, 1'b1);
        add_typed(OP_QUERY, -32768, -32768, 1'b0);
        add_item(OP_FREE_NBRS, 32767, 32767);     // steps past the 16-bit range drop
        add_item(OP_ALL_NBRS, -32768, -32768);
        add_typed(OP_RSVD_A, 123, -45, 1'b0);
        add_typed(OP_RSVD_B, -1, -1, 1'b0);
        add_typed(OP_CLEAR, 0, 0, 1'b0);
        add_typed(OP_QUERY, MAP_COLS - 1, MAP_ROWS - 1, 1'b0);
        // one-cell grid: every neighbor is out of bounds
        add_cfg(1, 1, 1'b1);
        add_typed(OP_FREE_NBRS, 0, 0, 1'b0);
        add_typed(OP_ALL_NBRS, 0, 0, 1'b0);
        add_cfg(32767, 32767, 1'b1);
        add_item(OP_FREE_NBRS, 0, 0);
        add_item(OP_ALL_NBRS, 32766, 32766);
        add_cfg(3, 0, 1'b1);
        add_typed(OP_BLOCK, 1, 1, 1'b1);
        add_item(OP_FREE_NBRS, 1, 0);

        settle();   // reset clearing pass
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                settle();
                program_grid(stim_rows[i].w, stim_rows[i].h, stim_rows[i].m);
            end else begin
                send_item(stim_rows[i].item, rand_gap(),
                          stim_rows[i].kind == ROW_TYPED, stim_rows[i].flag);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: program_grid(15'd7, 15'd5, 1'b0);
                1: program_grid(15'd0, 15'd0, 1'b1);
                2: program_grid(15'($urandom_range(1, 40)), 15'($urandom_range(1, 40)),
                                1'($urandom));
                3: program_grid(15'd300, 15'd200, 1'b1);
                4: program_grid(15'd32767, 15'd32767, 1'b0);
                default: program_grid(15'd1, 15'd0, 1'b1);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 20) drain();   // sender pause until all results are in
                it = rand_item();
                send_item(it, rand_gap(), 1'b0, 1'b0);
            end
        end

        settle();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/gne_pkg.sv
hdl/gne_ctrl.sv
hdl/gne_datapath.sv
hdl/grid_neighbor_expander.sv
tb/grid_neighbor_expander_tb.sv
